[design/ttc_pkg.sv]
// Shared constants, action codes and the step record of the tile console writer.
`default_nettype none

package ttc_pkg;

  localparam int DefColumns = 256 / 8;
  localparam int DefRows    = 256 / 8;

  localparam int TileW      = 7;
  localparam int MaxIdxW    = 12;
  localparam int FieldColW  = 5;
  localparam int FieldIdxW  = 10;
  localparam int InDataW    = 32;
  localparam int OutDataW   = 40;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_SET   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TILDE = 8'd126;

  // Outcome of one item as seen by the cursor logic.
  typedef struct packed {
    logic                 wr1;
    logic                 wr2;
    logic [MaxIdxW-1:0]   idx;
    logic [TileW-1:0]     tile;
    logic                 clr;
    logic [FieldColW-1:0] col;
    logic [FieldColW-1:0] row;
  } step_t;

endpackage

`default_nettype wire

[design/text_tile_console_writer.sv]
// Top level of the text tile console writer: beat control, map RAM and clear sweep.
//
// Input beats (s_axis) carry one command each: put character, set cursor,
// read map entry or clear map, selected by tuser. Output beats (m_axis)
// report the tile written, the data read, the cursor after the command and
// whether the map was cleared; tlast marks the final beat of a command.
// A tab that writes two tiles gives two output beats, every other command one.
// Set cursor commands, and puts that neither write two tiles nor start a
// clear sweep, stream at one beat per cycle while the output register drains.
// A read passes the registered RAM read, then loads the result into the
// output register. A two-tile tab writes its tiles in turn through the
// single RAM write port. A clear command, or a put that runs the cursor off
// the last row, starts a sweep that writes space tiles over all COLUMNS*ROWS
// map entries (1024 at the default size), while no input beat is accepted.
// After reset the same sweep runs once before the first beat is taken.
// Output beats are held in a register; while the receiver stalls, the block
// finishes at most the current command and then holds s_axis_tready low.
`default_nettype none

module text_tile_console_writer import ttc_pkg::*; #(
  parameter int COLUMNS = DefColumns,
  parameter int ROWS    = DefRows
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // char_code[7:0], set_column[12:8], set_row[17:13], read_index[27:18]
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // action[1:0]
  input  wire logic [1:0]          s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // write_index[9:0], tile_code[16:10], read_data[23:17],
  // cursor_column[28:24], cursor_row[33:29]
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  // write_valid[0], cleared[1]
  output logic [1:0]               m_axis_tuser_o,
  output logic                     m_axis_tlast_o
);

  localparam int MapSize = COLUMNS * ROWS;
  localparam int IW      = $clog2(MapSize);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_TAB2,
    ST_CLEAR
  } state_e;

  state_e                state_q;
  logic                  m_valid_q;
  logic [OutDataW-1:0]   m_data_q;
  logic [1:0]            m_user_q;
  logic                  m_last_q;
  logic [IW-1:0]         tab_idx_q;
  logic                  tab_clr_q;
  logic                  rd_oob_q;
  logic [IW-1:0]         clr_cnt_q;

  logic                  out_free;
  logic                  acc;
  action_e               act;
  logic [7:0]            char_code;
  logic [FieldColW-1:0]  set_column;
  logic [FieldColW-1:0]  set_row;
  logic [FieldIdxW-1:0]  read_index;
  step_t                 step;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [TileW-1:0]      ram_wdata;
  logic                  ram_re;
  logic [TileW-1:0]      ram_rdata;

  function automatic logic [OutDataW-1:0] pack_out(
    input logic [FieldIdxW-1:0] widx,
    input logic [TileW-1:0]     tile,
    input logic [TileW-1:0]     rd,
    input logic [FieldColW-1:0] col,
    input logic [FieldColW-1:0] row
  );
    return {6'd0, row, col, rd, tile, widx};
  endfunction

  assign char_code  = s_axis_tdata_i[7:0];
  assign set_column = s_axis_tdata_i[12:8];
  assign set_row    = s_axis_tdata_i[17:13];
  assign read_index = s_axis_tdata_i[27:18];
  assign act        = action_e'(s_axis_tuser_i);

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  ttc_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (acc),
    .action_i  (act),
    .char_i    (char_code),
    .set_col_i (set_column),
    .set_row_i (set_row),
    .step_o    (step)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = step.idx[IW-1:0];
    ram_wdata = step.tile;
    unique case (state_q)
      ST_IDLE:  ram_we = acc && (act == ACT_PUT) && step.wr1;
      ST_TAB2: begin
        ram_we    = out_free;
        ram_waddr = tab_idx_q;
        ram_wdata = '0;
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
      end
      ST_READ:  ram_we = 1'b0;
    endcase
  end

  assign ram_re = acc && (act == ACT_READ);

  ttc_ram #(
    .Width (TileW),
    .Depth (MapSize)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (IW'(read_index)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= '0;
      m_last_q  <= 1'b0;
      tab_idx_q <= '0;
      tab_clr_q <= 1'b0;
      rd_oob_q  <= 1'b0;
      clr_cnt_q <= '0;
    end else begin
      if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            m_valid_q <= 1'b1;
            m_last_q  <= 1'b1;
            m_user_q  <= 2'b00;
            m_data_q  <= pack_out('0, '0, '0, step.col, step.row);
            clr_cnt_q <= '0;
            unique case (act)
              ACT_PUT: begin
                if (step.wr2) begin
                  m_last_q  <= 1'b0;
                  m_user_q  <= 2'b01;
                  m_data_q  <= pack_out(FieldIdxW'(step.idx), '0, '0, step.col, step.row);
                  tab_idx_q <= step.idx[IW-1:0] + 1'b1;
                  tab_clr_q <= step.clr;
                  state_q   <= ST_TAB2;
                end else begin
                  m_user_q <= {step.clr, step.wr1};
                  if (step.wr1) begin
                    m_data_q <= pack_out(FieldIdxW'(step.idx), step.tile, '0, step.col,
                                         step.row);
                  end
                  if (step.clr) begin
                    state_q <= ST_CLEAR;
                  end
                end
              end
              ACT_SET: ;
              ACT_READ: begin
                m_valid_q <= 1'b0;
                rd_oob_q  <= {3'd0, read_index} >= 13'(MapSize);
                state_q   <= ST_READ;
              end
              ACT_CLEAR: begin
                m_user_q <= 2'b10;
                state_q  <= ST_CLEAR;
              end
            endcase
          end
        end
        ST_READ: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_last_q  <= 1'b1;
            m_user_q  <= 2'b00;
            m_data_q  <= pack_out('0, '0, rd_oob_q ? '0 : ram_rdata,
                                  m_data_q[28:24], m_data_q[33:29]);
            state_q   <= ST_IDLE;
          end
        end
        ST_TAB2: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_last_q  <= 1'b1;
            m_user_q  <= {tab_clr_q, 1'b1};
            m_data_q  <= pack_out(FieldIdxW'(tab_idx_q), '0, '0,
                                  m_data_q[28:24], m_data_q[33:29]);
            clr_cnt_q <= '0;
            state_q   <= tab_clr_q ? ST_CLEAR : ST_IDLE;
          end
        end
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == IW'(MapSize - 1)) begin
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  a_tab2_first_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAB2) |-> (m_valid_q && !m_last_q))
    else $error("second tab beat without pending first beat");

  a_scroll_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && act == ACT_PUT && step.clr && !step.wr2) |=>
      (state_q == ST_CLEAR && m_user_q[1]))
    else $error("scroll-off clear not started");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> ((IW+1)'(clr_cnt_q) < (IW+1)'(MapSize)))
    else $error("clear sweep beyond map");

  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> !ram_we)
    else $error("map write during read beat");

endmodule

`default_nettype wire

[design/ttc_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module ttc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/ttc_cursor.sv]
// Cursor registers and the per-item decode of writes, wrap and scroll-off clear.
`default_nettype none

module ttc_cursor import ttc_pkg::*; #(
  parameter int COLUMNS = DefColumns,
  parameter int ROWS    = DefRows
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 upd_i,
  input  wire action_e              action_i,
  input  wire logic [7:0]           char_i,
  input  wire logic [FieldColW-1:0] set_col_i,
  input  wire logic [FieldColW-1:0] set_row_i,
  output step_t                     step_o
);

  localparam int CW = $clog2(COLUMNS);
  localparam int LW = $clog2(ROWS);
  localparam int IW = $clog2(COLUMNS * ROWS);

  logic [CW-1:0] col_q;
  logic [LW-1:0] row_q;
  logic [CW:0]   ncol;
  logic [LW:0]   nrow;
  logic [IW-1:0] base;
  logic [6:0]    sc_w;
  logic [6:0]    sr_w;
  logic          wr1;
  logic          wr2;
  logic          clr;
  logic [TileW-1:0] tile;

  always_comb begin
    base = IW'(row_q) * IW'(COLUMNS) + IW'(col_q);
    sc_w = 7'(set_col_i);
    sr_w = 7'(set_row_i);
    ncol = {1'b0, col_q};
    nrow = {1'b0, row_q};
    wr1  = 1'b0;
    wr2  = 1'b0;
    clr  = 1'b0;
    tile = '0;
    unique case (action_i)
      ACT_SET: begin
        ncol = (sc_w < 7'(COLUMNS)) ? (CW+1)'(sc_w) : (CW+1)'(COLUMNS - 1);
        nrow = (sr_w < 7'(ROWS)) ? (LW+1)'(sr_w) : (LW+1)'(ROWS - 1);
      end
      ACT_PUT: begin
        if (char_i != CH_NUL) begin
          unique case (char_i)
            CH_TAB: begin
              wr1  = 1'b1;
              wr2  = ({1'b0, col_q} + 1'b1) < (CW+1)'(COLUMNS);
              ncol = {1'b0, col_q} + (CW+1)'(2);
            end
            CH_BS: begin
              if (col_q != '0) begin
                ncol = {1'b0, col_q} - 1'b1;
              end
            end
            CH_CR: ncol = '0;
            CH_LF: begin
              ncol = '0;
              nrow = {1'b0, row_q} + 1'b1;
            end
            default: begin
              wr1  = 1'b1;
              if (char_i >= CH_SPACE && char_i <= CH_TILDE) begin
                tile = TileW'(char_i - CH_SPACE);
              end
              ncol = {1'b0, col_q} + 1'b1;
            end
          endcase
          if (ncol >= (CW+1)'(COLUMNS)) begin
            ncol = '0;
            nrow = nrow + 1'b1;
          end
          if (nrow >= (LW+1)'(ROWS)) begin
            ncol = '0;
            nrow = '0;
            clr  = 1'b1;
          end
        end
      end
      ACT_READ, ACT_CLEAR: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (upd_i) begin
      col_q <= ncol[CW-1:0];
      row_q <= nrow[LW-1:0];
    end
  end

  assign step_o = '{
    wr1:  wr1,
    wr2:  wr2,
    idx:  MaxIdxW'(base),
    tile: tile,
    clr:  clr,
    col:  FieldColW'(ncol[CW-1:0]),
    row:  FieldColW'(nrow[LW-1:0])
  };

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW+1)'(col_q) < (CW+1)'(COLUMNS))
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LW+1)'(row_q) < (LW+1)'(ROWS))
    else $error("cursor row out of range");

  a_clr_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_i && clr) |=> (col_q == '0 && row_q == '0))
    else $error("cursor not homed after scroll-off clear");

endmodule

`default_nettype wire
